@@ hw/rtl/tksd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_pkg
// Shared types, key numbers and lookup functions of the terminal key
// sequence decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ESC    = 4'd1,
    PH_SS3    = 4'd2,
    PH_CSI    = 4'd3,
    PH_CSI1   = 4'd4,
    PH_CSIMOD = 4'd5,
    PH_CSIFIN = 4'd6,
    PH_TILDE  = 4'd7,
    PH_CSIBR  = 4'd8,
    PH_PC     = 4'd9
  } phase_t;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_EOI  = 2'd2;

  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_BRKT  = 8'h5B;
  localparam logic [7:0] BYTE_SS3   = 8'h4F;
  localparam logic [7:0] BYTE_TILDE = 8'h7E;
  localparam logic [7:0] BYTE_SEMI  = 8'h3B;
  localparam logic [7:0] BYTE_PCEXT = 8'hE0;
  localparam logic [7:0] BYTE_PCNUL = 8'h00;

  localparam logic [5:0] K_UNKNOWN = 6'd0;
  localparam logic [5:0] K_BS      = 6'd1;
  localparam logic [5:0] K_TAB     = 6'd2;
  localparam logic [5:0] K_STAB    = 6'd3;
  localparam logic [5:0] K_CTAB    = 6'd4;
  localparam logic [5:0] K_ENTER   = 6'd5;
  localparam logic [5:0] K_ESC     = 6'd6;
  localparam logic [5:0] K_F1      = 6'd7;
  localparam logic [5:0] K_F3      = 6'd8;
  localparam logic [5:0] K_F5      = 6'd9;
  localparam logic [5:0] K_INS     = 6'd10;
  localparam logic [5:0] K_DEL     = 6'd11;
  localparam logic [5:0] K_PGUP    = 6'd12;
  localparam logic [5:0] K_SPGUP   = 6'd13;
  localparam logic [5:0] K_PGDN    = 6'd14;
  localparam logic [5:0] K_SPGDN   = 6'd15;
  localparam logic [5:0] K_HOME    = 6'd16;
  localparam logic [5:0] K_END     = 6'd20;
  localparam logic [5:0] K_UP      = 6'd24;
  localparam logic [5:0] K_DOWN    = 6'd28;
  localparam logic [5:0] K_LEFT    = 6'd32;
  localparam logic [5:0] K_RIGHT   = 6'd36;
  localparam logic [5:0] K_LAST    = 6'd39;

  localparam logic [5:0] MOD_SHIFT = 6'd1;
  localparam logic [5:0] MOD_CTRL  = 6'd2;
  localparam logic [5:0] MOD_BOTH  = 6'd3;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
    logic       shift_held;
    logic       ctrl_held;
  } tksd_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [5:0] pending;
    logic       shift;
    logic       ctrl;
  } tksd_state_t;

  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] chr;
    logic [5:0] key;
  } tksd_res_t;

  function automatic logic [5:0] ss3_key(input logic eoi, input logic [7:0] c);
    logic [5:0] k;
    k = K_UNKNOWN;
    if (!eoi) begin
      case (c)
        8'h46:   k = K_END;
        8'h48:   k = K_HOME;
        8'h50:   k = K_F1;
        8'h52:   k = K_F3;
        8'h54:   k = K_F5;
        default: k = K_UNKNOWN;
      endcase
    end
    return k;
  endfunction

  function automatic logic [5:0] pc_key(input logic eoi, input logic [7:0] c);
    logic [5:0] k;
    k = K_UNKNOWN;
    if (!eoi) begin
      case (c)
        8'h0F:   k = K_STAB;
        8'h3B:   k = K_F1;
        8'h3D:   k = K_F3;
        8'h3F:   k = K_F5;
        8'h47:   k = K_HOME;
        8'h48:   k = K_UP;
        8'h49:   k = K_PGUP;
        8'h4B:   k = K_LEFT;
        8'h4D:   k = K_RIGHT;
        8'h4F:   k = K_END;
        8'h50:   k = K_DOWN;
        8'h51:   k = K_PGDN;
        8'h52:   k = K_INS;
        8'h53:   k = K_DEL;
        8'h73:   k = K_LEFT + MOD_CTRL;
        8'h74:   k = K_RIGHT + MOD_CTRL;
        8'h75:   k = K_END + MOD_CTRL;
        8'h77:   k = K_HOME + MOD_CTRL;
        8'h8D:   k = K_UP + MOD_CTRL;
        8'h91:   k = K_DOWN + MOD_CTRL;
        8'h94:   k = K_CTAB;
        8'hB8:   k = K_UP + MOD_SHIFT;
        8'hB7:   k = K_HOME + MOD_SHIFT;
        8'hBF:   k = K_END + MOD_SHIFT;
        8'hB9:   k = K_SPGUP;
        8'hBB:   k = K_LEFT + MOD_SHIFT;
        8'hBD:   k = K_RIGHT + MOD_SHIFT;
        8'hC0:   k = K_DOWN + MOD_SHIFT;
        8'hC1:   k = K_SPGDN;
        8'hDB:   k = K_LEFT + MOD_BOTH;
        8'hDD:   k = K_RIGHT + MOD_BOTH;
        8'hD8:   k = K_UP + MOD_BOTH;
        8'hE0:   k = K_DOWN + MOD_BOTH;
        8'hD7:   k = K_HOME + MOD_BOTH;
        8'hDF:   k = K_END + MOD_BOTH;
        default: k = K_UNKNOWN;
      endcase
    end
    return k;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tksd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_if
// Valid/ready channels of the terminal key sequence decoder: terminal
// byte input and decoded result output.
// ----------------------------------------------------------------------------
interface tksd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_input;
  logic       shift_held;
  logic       ctrl_held;

  modport source (output valid, output byte_in, output end_of_input,
                  output shift_held, output ctrl_held, input ready);
  modport sink (input valid, input byte_in, input end_of_input,
                input shift_held, input ctrl_held, output ready);
endinterface

interface tksd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] char_code;
  logic [5:0] key_code;

  modport source (output valid, output result_kind, output char_code,
                  output key_code, input ready);
  modport sink (input valid, input result_kind, input char_code,
                input key_code, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/terminal_key_sequence_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder
// Turns terminal bytes into plain characters and decoded key codes.
//
// in_ch carries one terminal byte per transaction with the console shift
// and ctrl state and an end-of-input flag. out_ch carries at most one
// result per input transaction: a character, a key code or end of input.
// Bytes inside an escape sequence produce no out_ch transaction.
// A result passes the input register, then the parse step into the output
// register, before it is offered on out_ch.
// Throughput: one byte per cycle unless out_ch stalls; the parse state
// register updates in the same cycle the byte leaves the input register.
// When out_ch stalls with a result held, the input register keeps its
// byte and in_ch.ready follows whether that register can drain.
// Reset clears the parse state to idle and empties both registers.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder (
  input  wire        clk,
  input  wire        rst_n,
  tksd_in_if.sink    in_ch,
  tksd_out_if.source out_ch
);
  import tksd_pkg::*;

  logic        item_valid_r;
  tksd_item_t  item_r;
  tksd_state_t state_r;
  tksd_state_t state_nxt;
  tksd_res_t   res;
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_char_r;
  logic [5:0]  out_key_r;
  logic        step;
  logic        in_take;

  assign step    = item_valid_r && (!out_valid_r || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready        = !item_valid_r || step;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.char_code   = out_char_r;
  assign out_ch.key_code    = out_key_r;

  tksd_decode u_decode (
    .st     (state_r),
    .item   (item_r),
    .st_nxt (state_nxt),
    .res    (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.byte_in      <= in_ch.byte_in;
      item_r.end_of_input <= in_ch.end_of_input;
      item_r.shift_held   <= in_ch.shift_held;
      item_r.ctrl_held    <= in_ch.ctrl_held;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase   <= PH_IDLE;
      state_r.pending <= K_UNKNOWN;
      state_r.shift   <= 1'b0;
      state_r.ctrl    <= 1'b0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_kind_r <= res.kind;
      out_char_r <= res.chr;
      out_key_r  <= res.key;
    end
  end

  // checks
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_kind_r == KIND_CHAR || out_kind_r == KIND_KEY ||
                     out_kind_r == KIND_EOI))
    else $error("illegal result kind");

  a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_KEY) |-> (out_key_r <= K_LAST && out_char_r == 8'd0))
    else $error("key result out of range or with character");

  a_char_no_key: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_KEY) |-> (out_key_r == K_UNKNOWN))
    else $error("non-key result carries a key code");

  a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.emit && res.kind == KIND_EOI) |=> (state_r.phase == PH_IDLE))
    else $error("end of input left parser outside idle");

endmodule
`default_nettype wire

@@ hw/rtl/tksd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_decode
// One-byte step of the escape sequence parser: next parse state and the
// result, if any, for the registered byte.
// ----------------------------------------------------------------------------
module tksd_decode (
  input  var tksd_pkg::tksd_state_t st,
  input  var tksd_pkg::tksd_item_t  item,
  output tksd_pkg::tksd_state_t     st_nxt,
  output tksd_pkg::tksd_res_t       res
);
  import tksd_pkg::*;

  logic       eoi;
  logic [7:0] c;
  logic [1:0] mods;
  logic       csi_emit;
  logic [5:0] csi_key;
  phase_t     csi_phase;
  logic [5:0] csi_pend;

  assign eoi  = item.end_of_input;
  assign c    = item.byte_in;
  assign mods = {st.ctrl, st.shift};

  function automatic logic [5:0] with_mods(input logic [5:0] base, input logic [1:0] m);
    return {base[5:2], m};
  endfunction

  // body or final byte of a csi sequence
  always_comb begin
    csi_emit  = 1'b1;
    csi_key   = K_UNKNOWN;
    csi_phase = PH_IDLE;
    csi_pend  = st.pending;
    if (!eoi) begin
      case (c)
        8'h31: begin
          csi_emit = 1'b0; csi_phase = PH_TILDE; csi_pend = with_mods(K_HOME, mods);
        end
        8'h32: begin
          csi_emit = 1'b0; csi_phase = PH_TILDE; csi_pend = K_INS;
        end
        8'h33: begin
          csi_emit = 1'b0; csi_phase = PH_TILDE; csi_pend = K_DEL;
        end
        8'h34: begin
          csi_emit = 1'b0; csi_phase = PH_TILDE; csi_pend = with_mods(K_END, mods);
        end
        8'h35: begin
          csi_emit = 1'b0; csi_phase = PH_TILDE; csi_pend = st.shift ? K_SPGUP : K_PGUP;
        end
        8'h36: begin
          csi_emit = 1'b0; csi_phase = PH_TILDE; csi_pend = st.shift ? K_SPGDN : K_PGDN;
        end
        8'h41:     csi_key = with_mods(K_UP, mods);
        8'h42:     csi_key = with_mods(K_DOWN, mods);
        8'h43:     csi_key = with_mods(K_RIGHT, mods);
        8'h44:     csi_key = with_mods(K_LEFT, mods);
        8'h46:     csi_key = with_mods(K_END, mods);
        8'h48:     csi_key = with_mods(K_HOME, mods);
        8'h5A:     csi_key = K_STAB;
        BYTE_BRKT: begin
          csi_emit = 1'b0; csi_phase = PH_CSIBR;
        end
        default:   csi_key = K_UNKNOWN;
      endcase
    end
  end

  // next state
  always_comb begin
    st_nxt = st;
    case (st.phase)
      PH_ESC: begin
        if (!eoi && c == BYTE_SS3) begin
          st_nxt.phase = PH_SS3;
        end else if (!eoi && c == BYTE_BRKT) begin
          st_nxt.phase = PH_CSI;
          st_nxt.shift = item.shift_held;
          st_nxt.ctrl  = item.ctrl_held;
        end else begin
          st_nxt.phase = PH_IDLE;
        end
      end
      PH_CSI: begin
        if (!eoi && c == 8'h31) begin
          st_nxt.phase = PH_CSI1;
        end else begin
          st_nxt.phase   = csi_phase;
          st_nxt.pending = csi_pend;
        end
      end
      PH_CSI1: begin
        if (!eoi && c == BYTE_SEMI) begin
          st_nxt.phase = PH_CSIMOD;
        end else if (!eoi && c == 8'h35) begin
          st_nxt.phase   = PH_TILDE;
          st_nxt.pending = K_F5;
        end else begin
          st_nxt.phase = PH_IDLE;
        end
      end
      PH_CSIMOD: begin
        if (!eoi && (c == 8'h32 || c == 8'h36)) begin
          st_nxt.shift = 1'b1;
        end
        if (!eoi && (c == 8'h35 || c == 8'h36)) begin
          st_nxt.ctrl = 1'b1;
        end
        st_nxt.phase = PH_CSIFIN;
      end
      PH_CSIFIN: begin
        st_nxt.phase   = csi_phase;
        st_nxt.pending = csi_pend;
      end
      PH_SS3, PH_TILDE, PH_CSIBR, PH_PC: begin
        st_nxt.phase = PH_IDLE;
      end
      default: begin
        if (eoi) begin
          st_nxt.phase = PH_IDLE;
        end else if (c == BYTE_ESC) begin
          st_nxt.phase = PH_ESC;
        end else if (c == BYTE_PCNUL || c == BYTE_PCEXT) begin
          st_nxt.phase = PH_PC;
        end else begin
          st_nxt.phase = PH_IDLE;
        end
      end
    endcase
  end

  // result
  always_comb begin
    res.emit = 1'b0;
    res.kind = KIND_KEY;
    res.chr  = 8'd0;
    res.key  = K_UNKNOWN;
    case (st.phase)
      PH_ESC: begin
        if (!eoi && c == BYTE_ESC) begin
          res.emit = 1'b1;
          res.key  = K_ESC;
        end else if (!eoi && (c == BYTE_SS3 || c == BYTE_BRKT)) begin
          res.emit = 1'b0;
        end else begin
          res.emit = 1'b1;
        end
      end
      PH_SS3: begin
        res.emit = 1'b1;
        res.key  = ss3_key(eoi, c);
      end
      PH_CSI: begin
        if (!(!eoi && c == 8'h31)) begin
          res.emit = csi_emit;
          res.key  = csi_key;
        end
      end
      PH_CSI1: begin
        if (!eoi && c == BYTE_TILDE) begin
          res.emit = 1'b1;
          res.key  = with_mods(K_HOME, mods);
        end else if (!(!eoi && (c == BYTE_SEMI || c == 8'h35))) begin
          res.emit = 1'b1;
        end
      end
      PH_CSIMOD: begin
        res.emit = 1'b0;
      end
      PH_CSIFIN: begin
        res.emit = csi_emit;
        res.key  = csi_key;
      end
      PH_TILDE: begin
        res.emit = 1'b1;
        res.key  = (!eoi && c == BYTE_TILDE) ? st.pending : K_UNKNOWN;
      end
      PH_CSIBR: begin
        res.emit = 1'b1;
        if (!eoi && c == 8'h41) begin
          res.key = K_F1;
        end else if (!eoi && c == 8'h43) begin
          res.key = K_F3;
        end else if (!eoi && c == 8'h45) begin
          res.key = K_F5;
        end
      end
      PH_PC: begin
        res.emit = 1'b1;
        res.key  = pc_key(eoi, c);
      end
      default: begin
        if (eoi) begin
          res.emit = 1'b1;
          res.kind = KIND_EOI;
        end else begin
          case (c)
            8'h08, 8'h7F: begin
              res.emit = 1'b1;
              res.key  = K_BS;
            end
            8'h09: begin
              res.emit = 1'b1;
              res.key  = item.shift_held ? K_STAB : (item.ctrl_held ? K_CTAB : K_TAB);
            end
            8'h0A, 8'h0D: begin
              res.emit = 1'b1;
              res.key  = K_ENTER;
            end
            BYTE_ESC, BYTE_PCNUL, BYTE_PCEXT: begin
              res.emit = 1'b0;
            end
            default: begin
              res.emit = 1'b1;
              res.kind = KIND_CHAR;
              res.chr  = c;
            end
          endcase
        end
      end
    endcase
  end

endmodule
`default_nettype wire
